// ===== design/pfrt_pkg.sv =====
// shared types, register indexes and constants of the pixel row frame tracker
package pfrt_pkg;

   localparam int WordWidth  = 64;
   localparam int DepthWidth = 5;
   localparam int PpwWidth   = 6;
   localparam int CountWidth = 9;
   localparam int FrameWidth = 17;
   localparam int TotalWidth = 32;
   localparam int ShutWidth  = 16;
   localparam int CsrIdxWidth = 3;
   localparam int DefaultColumns = 256;
   localparam int DefaultRows    = 256;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_BYTE_REVERSE     = 3'd0,
      CSR_PIXEL_DEPTH      = 3'd1,
      CSR_TYPE_MASK        = 3'd2,
      CSR_CODE_START_FRAME = 3'd3,
      CSR_CODE_START_ROW   = 3'd4,
      CSR_CODE_MID_ROW     = 3'd5,
      CSR_CODE_END_ROW     = 3'd6,
      CSR_CODE_END_FRAME   = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_OTHER,
      KIND_START_ROW,
      KIND_END_ROW,
      KIND_START_FRAME,
      KIND_END_FRAME,
      KIND_MID_ROW
   } kind_type;

   typedef struct packed {
      logic                 byte_reverse;
      logic [WordWidth-1:0] type_mask;
      logic [WordWidth-1:0] start_frame;
      logic [WordWidth-1:0] start_row;
      logic [WordWidth-1:0] mid_row;
      logic [WordWidth-1:0] end_row;
      logic [WordWidth-1:0] end_frame;
   } class_cfg_type;

   localparam logic [WordWidth-1:0] RESET_TYPE_MASK   = 64'hF000_0000_0000_0000;
   localparam logic [WordWidth-1:0] RESET_START_FRAME = 64'h6000_0000_0000_0000;
   localparam logic [WordWidth-1:0] RESET_START_ROW   = 64'h4000_0000_0000_0000;
   localparam logic [WordWidth-1:0] RESET_MID_ROW     = 64'h3000_0000_0000_0000;
   localparam logic [WordWidth-1:0] RESET_END_ROW     = 64'h5000_0000_0000_0000;
   localparam logic [WordWidth-1:0] RESET_END_FRAME   = 64'h7000_0000_0000_0000;

   // pixels per word for each depth, depth zero counts as one
   localparam logic [PpwWidth-1:0] PPW_TABLE [32] = '{
      6'd60, 6'd60, 6'd30, 6'd20, 6'd15, 6'd12, 6'd10, 6'd8,
      6'd7,  6'd6,  6'd6,  6'd5,  6'd5,  6'd4,  6'd4,  6'd4,
      6'd3,  6'd3,  6'd3,  6'd3,  6'd3,  6'd2,  6'd2,  6'd2,
      6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd1
   };

   localparam logic [PpwWidth-1:0] RESET_PPW = 6'd5;

endpackage

// ===== design/pfrt_classify.sv =====
// byte reversal and word type decode
module pfrt_classify (
   input  logic [pfrt_pkg::WordWidth-1:0] word_in,
   input  pfrt_pkg::class_cfg_type        cfg,
   output logic [pfrt_pkg::WordWidth-1:0] word_out,
   output pfrt_pkg::kind_type             kind
);

   logic [pfrt_pkg::WordWidth-1:0] type_bits;

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         word_out[8*k +: 8] = cfg.byte_reverse ? word_in[8*(7-k) +: 8] : word_in[8*k +: 8];
      end
   end

   assign type_bits = word_out & cfg.type_mask;

   // first match wins
   always_comb begin
      if (type_bits == cfg.start_row) begin
         kind = pfrt_pkg::KIND_START_ROW;
      end else if (type_bits == cfg.end_row) begin
         kind = pfrt_pkg::KIND_END_ROW;
      end else if (type_bits == cfg.start_frame) begin
         kind = pfrt_pkg::KIND_START_FRAME;
      end else if (type_bits == cfg.end_frame) begin
         kind = pfrt_pkg::KIND_END_FRAME;
      end else if (type_bits == cfg.mid_row) begin
         kind = pfrt_pkg::KIND_MID_ROW;
      end else begin
         kind = pfrt_pkg::KIND_OTHER;
      end
   end

endmodule

// ===== design/pixel_row_frame_tracker.sv =====
// pixel row frame tracker: word decode, row and frame counters, result register
//
// The req channel takes one 64-bit pixel word per transfer. Each word is decoded
// by its masked type bits, the row and frame counters are updated in the cycle
// of the transfer, and exactly one result is loaded into the rsp register.
// rsp_valid is set in the cycle after a req transfer. Throughput is one
// word per cycle: req_ready stays high while the rsp register is empty or is
// being taken in the same cycle, so a stalled receiver holds the result and
// stops new words only while it stalls. The per-word path is the type
// compares, a saturating pixel add and the 32-bit totals.
// Words of unknown type give a result with rsp_word_kept low.
// Reset clears all counters (pixel count of the row to the column count,
// shutter to one), empties the rsp register and loads the register defaults.
// The csr port writes a register with no read-back; writes are
// expected only while no word is in flight.
module pixel_row_frame_tracker #(
   parameter int COLUMNS = pfrt_pkg::DefaultColumns,
   parameter int ROWS    = pfrt_pkg::DefaultRows
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [pfrt_pkg::WordWidth-1:0]      req_pixel_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pfrt_pkg::WordWidth-1:0]      rsp_word_out,
   output logic                                rsp_word_kept,
   output logic [pfrt_pkg::FrameWidth-1:0]     rsp_word_index,
   output logic                                rsp_frame_closed,
   output logic [pfrt_pkg::FrameWidth-1:0]     rsp_closed_frame_lost,
   output logic [pfrt_pkg::FrameWidth-1:0]     rsp_closed_frame_words,
   output logic [pfrt_pkg::TotalWidth-1:0]     rsp_frames_total,
   output logic [pfrt_pkg::TotalWidth-1:0]     rsp_pixels_received_total,
   output logic [pfrt_pkg::TotalWidth-1:0]     rsp_pixels_lost_total,
   output logic [pfrt_pkg::ShutWidth-1:0]      rsp_shutter_number,
   output logic [pfrt_pkg::CountWidth-1:0]     rsp_rows_seen,
   input  logic                                csr_write_enable,
   input  logic [pfrt_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [pfrt_pkg::WordWidth-1:0]      csr_write_data
);

   localparam int CW = pfrt_pkg::CountWidth;
   localparam int FW = pfrt_pkg::FrameWidth;
   localparam int TW = pfrt_pkg::TotalWidth;
   localparam int PW = pfrt_pkg::PpwWidth;
   localparam logic [CW-1:0] COLS_C  = CW'(COLUMNS);
   localparam logic [CW-1:0] ROWS_C  = CW'(ROWS);
   localparam logic [FW-1:0] COLS_F  = FW'(COLUMNS);
   localparam logic [CW-1:0] SAT_C   = {CW{1'b1}};
   localparam logic [FW-1:0] SAT_F   = {FW{1'b1}};

   // configuration
   pfrt_pkg::class_cfg_type cfg_ff;
   logic [PW-1:0]           ppw_ff;

   // tracking state
   logic [CW-1:0]                     row_count_ff, row_count_in;
   logic [CW-1:0]                     row_pixel_ff, row_pixel_in;
   logic [FW-1:0]                     frame_lost_ff, frame_lost_in;
   logic [FW-1:0]                     frame_words_ff, frame_words_in;
   logic [TW-1:0]                     received_ff, received_in;
   logic [TW-1:0]                     lost_total_ff, lost_total_in;
   logic [TW-1:0]                     frame_total_ff, frame_total_in;
   logic [pfrt_pkg::ShutWidth-1:0]    shutter_ff, shutter_in;

   // result register
   logic                              rsp_valid_ff;
   logic [pfrt_pkg::WordWidth-1:0]    word_out_ff;
   logic                              kept_ff, kept_in;
   logic [FW-1:0]                     index_ff, index_in;
   logic                              closed_ff, closed_in;
   logic [FW-1:0]                     closed_lost_ff, closed_lost_in;
   logic [FW-1:0]                     closed_words_ff, closed_words_in;

   logic [pfrt_pkg::WordWidth-1:0]    word_dec;
   pfrt_pkg::kind_type                kind;
   logic                              accept;

   logic [CW:0]    pixel_sum;
   logic [CW-1:0]  pixel_sat;
   logic [CW-1:0]  pixel_floor;
   logic [CW-1:0]  rc_base;
   logic [CW-1:0]  rc_inc;
   logic [CW-1:0]  lost_row;
   logic [FW-1:0]  lost_frame;
   logic [FW:0]    flc_sum_a, flc_sum_b;
   logic [FW-1:0]  flc_a;
   logic [FW:0]    fwc_sum;
   logic [FW-1:0]  fwc_inc;
   logic [CW-1:0]  pad;
   logic [PW-1:0]  rx_add;
   logic           close_early;
   logic           is_eof;

   pfrt_classify u_classify (
      .word_in  (req_pixel_word),
      .cfg      (cfg_ff),
      .word_out (word_dec),
      .kind     (kind)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.byte_reverse <= 1'b0;
         cfg_ff.type_mask    <= pfrt_pkg::RESET_TYPE_MASK;
         cfg_ff.start_frame  <= pfrt_pkg::RESET_START_FRAME;
         cfg_ff.start_row    <= pfrt_pkg::RESET_START_ROW;
         cfg_ff.mid_row      <= pfrt_pkg::RESET_MID_ROW;
         cfg_ff.end_row      <= pfrt_pkg::RESET_END_ROW;
         cfg_ff.end_frame    <= pfrt_pkg::RESET_END_FRAME;
         ppw_ff              <= pfrt_pkg::RESET_PPW;
      end else if (csr_write_enable) begin
         case (pfrt_pkg::csr_index_type'(csr_index))
            pfrt_pkg::CSR_BYTE_REVERSE:     cfg_ff.byte_reverse <= csr_write_data[0];
            pfrt_pkg::CSR_PIXEL_DEPTH:
               ppw_ff <= pfrt_pkg::PPW_TABLE[csr_write_data[pfrt_pkg::DepthWidth-1:0]];
            pfrt_pkg::CSR_TYPE_MASK:        cfg_ff.type_mask   <= csr_write_data;
            pfrt_pkg::CSR_CODE_START_FRAME: cfg_ff.start_frame <= csr_write_data;
            pfrt_pkg::CSR_CODE_START_ROW:   cfg_ff.start_row   <= csr_write_data;
            pfrt_pkg::CSR_CODE_MID_ROW:     cfg_ff.mid_row     <= csr_write_data;
            pfrt_pkg::CSR_CODE_END_ROW:     cfg_ff.end_row     <= csr_write_data;
            pfrt_pkg::CSR_CODE_END_FRAME:   cfg_ff.end_frame   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // shared arithmetic
   always_comb begin
      pixel_sum   = {1'b0, row_pixel_ff} + (CW+1)'(ppw_ff);
      pixel_sat   = pixel_sum[CW] ? SAT_C : pixel_sum[CW-1:0];
      pixel_floor = (pixel_sat < COLS_C) ? COLS_C : pixel_sat;
      rc_base     = (kind == pfrt_pkg::KIND_START_ROW && row_count_ff == '0) ?
                    CW'(1) : row_count_ff;
      rc_inc      = (rc_base == SAT_C) ? SAT_C : rc_base + CW'(1);
   end

   // next state and result
   always_comb begin
      lost_row     = '0;
      lost_frame   = '0;
      close_early  = 1'b0;
      is_eof       = 1'b0;
      kept_in      = 1'b1;
      row_count_in = row_count_ff;
      row_pixel_in = row_pixel_ff;

      case (kind)
         pfrt_pkg::KIND_START_ROW: begin
            if (row_pixel_ff < COLS_C) lost_row = COLS_C - row_pixel_ff;
            row_count_in = rc_inc;
            close_early  = rc_inc > ROWS_C;
            row_pixel_in = CW'(ppw_ff);
         end
         pfrt_pkg::KIND_END_ROW: begin
            if (pixel_sat < COLS_C) lost_row = COLS_C - pixel_sat;
            row_pixel_in = pixel_floor;
            if (row_count_ff >= ROWS_C) begin
               row_pixel_in = CW'(ppw_ff);
               close_early  = 1'b1;
            end
         end
         pfrt_pkg::KIND_START_FRAME: begin
            if (row_pixel_ff < COLS_C) lost_row = COLS_C - row_pixel_ff;
            row_count_in = rc_inc;
            row_pixel_in = CW'(ppw_ff);
         end
         pfrt_pkg::KIND_END_FRAME: begin
            is_eof = 1'b1;
            if (pixel_sat < COLS_C) lost_row = COLS_C - pixel_sat;
            row_pixel_in = pixel_floor;
            if (row_count_ff < ROWS_C) lost_frame = FW'(ROWS_C - row_count_ff) * COLS_F;
         end
         pfrt_pkg::KIND_MID_ROW: begin
            row_pixel_in = pixel_sat;
            if (pixel_sat >= COLS_C) begin
               row_count_in = rc_inc;
               close_early  = rc_inc > ROWS_C;
               row_pixel_in = CW'(ppw_ff);
            end
         end
         default: kept_in = 1'b0;
      endcase

      flc_sum_a = {1'b0, frame_lost_ff} + (FW+1)'(lost_row);
      flc_a     = flc_sum_a[FW] ? SAT_F : flc_sum_a[FW-1:0];
      flc_sum_b = {1'b0, flc_a} + {1'b0, lost_frame};

      lost_total_in = lost_total_ff + TW'(lost_row) + TW'(lost_frame);

      fwc_sum = close_early ? (FW+1)'(1) : {1'b0, frame_words_ff} + (FW+1)'(1);
      fwc_inc = fwc_sum[FW] ? SAT_F : fwc_sum[FW-1:0];

      index_in  = (kept_in && !close_early) ? frame_words_ff : '0;
      closed_in = close_early || (is_eof && kept_in);

      if (close_early) begin
         closed_lost_in  = flc_a;
         closed_words_in = frame_words_ff;
      end else if (is_eof) begin
         closed_lost_in  = flc_sum_b[FW] ? SAT_F : flc_sum_b[FW-1:0];
         closed_words_in = fwc_inc;
      end else begin
         closed_lost_in  = '0;
         closed_words_in = '0;
      end

      if (closed_in) begin
         row_count_in   = '0;
         frame_lost_in  = '0;
         frame_total_in = frame_total_ff + TW'(1);
         shutter_in     = shutter_ff + 16'd1;
      end else begin
         frame_lost_in  = flc_a;
         frame_total_in = frame_total_ff;
         shutter_in     = shutter_ff;
      end

      if (!kept_in) begin
         frame_words_in = frame_words_ff;
      end else if (is_eof) begin
         frame_words_in = '0;
      end else begin
         frame_words_in = fwc_inc;
      end

      pad    = row_pixel_in - COLS_C;
      rx_add = '0;
      if (row_pixel_in > COLS_C) begin
         if (pad < CW'(ppw_ff)) rx_add = ppw_ff - PW'(pad);
      end else begin
         rx_add = ppw_ff;
      end
      received_in = kept_in ? received_ff + TW'(rx_add) : received_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff   <= '0;
         row_pixel_ff   <= COLS_C;
         frame_lost_ff  <= '0;
         frame_words_ff <= '0;
         received_ff    <= '0;
         lost_total_ff  <= '0;
         frame_total_ff <= '0;
         shutter_ff     <= 16'd1;
      end else if (accept) begin
         row_count_ff   <= row_count_in;
         row_pixel_ff   <= row_pixel_in;
         frame_lost_ff  <= frame_lost_in;
         frame_words_ff <= frame_words_in;
         received_ff    <= received_in;
         lost_total_ff  <= lost_total_in;
         frame_total_ff <= frame_total_in;
         shutter_ff     <= shutter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_out_ff     <= word_dec;
         kept_ff         <= kept_in;
         index_ff        <= index_in;
         closed_ff       <= closed_in;
         closed_lost_ff  <= closed_lost_in;
         closed_words_ff <= closed_words_in;
      end
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_word_out              = word_out_ff;
   assign rsp_word_kept             = kept_ff;
   assign rsp_word_index            = index_ff;
   assign rsp_frame_closed          = closed_ff;
   assign rsp_closed_frame_lost     = closed_lost_ff;
   assign rsp_closed_frame_words    = closed_words_ff;
   assign rsp_frames_total          = frame_total_ff;
   assign rsp_pixels_received_total = received_ff;
   assign rsp_pixels_lost_total     = lost_total_ff;
   assign rsp_shutter_number        = shutter_ff;
   assign rsp_rows_seen             = row_count_ff;

   a_accept_loads_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted word gave no result");

   a_dropped_never_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word_kept |-> !rsp_frame_closed && rsp_word_index == '0)
      else $error("dropped word closed a frame or carried an index");

   a_close_clears_rows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_closed |-> rsp_rows_seen == '0)
      else $error("frame closed with rows still counted");

   a_close_bumps_frames: assert property (@(posedge clock) disable iff (reset)
      accept && closed_in |=> rsp_frames_total == $past(frame_total_ff) + 32'd1)
      else $error("frame close did not advance the frame total");

endmodule
